// ===== hw/rtl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg
// shared types and constants of the path conflict detector
// ----------------------------------------------------------------------------
`default_nettype none

package pcd_pkg;

  localparam int unsigned MaxAgentsDef = 32;
  localparam int unsigned CoordBitsDef = 10;
  localparam int unsigned StepW        = 12;
  localparam int unsigned AgentW       = 5;
  localparam int unsigned PosW         = 10;
  localparam int unsigned AgentSlots   = 32;

  typedef enum logic [2:0] {
    StIdle,
    StOcc,
    StHist,
    StMove,
    StFinish
  } pcd_state_e;

  localparam logic KindVertex = 1'b0;
  localparam logic KindEdge   = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/path_conflict_detector_unit.sv =====
// ----------------------------------------------------------------------------
// path_conflict_detector_unit
// per-step vertex and swap conflict check of agent positions
// ----------------------------------------------------------------------------
// channel | dir | handshake               | payload
// in      | in  | in_valid_i / in_ready_o | step, agent, cell_row, cell_col
// out     | out | out_valid_o/out_ready_i | kind .. conflict_step, last
//
// the occupancy table is scanned, then the move table as well when the agent
// moved; the scans read one memory entry per cycle
// items are handled one at a time; a result that cannot reach a full output
// register holds the scan in place
// reset clears the counts, the step flag and the history valid bits at once
// ----------------------------------------------------------------------------
`default_nettype none

module path_conflict_detector_unit #(
  parameter int unsigned MAX_AGENTS = pcd_pkg::MaxAgentsDef,
  parameter int unsigned COORD_BITS = pcd_pkg::CoordBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [pcd_pkg::StepW-1:0]  step_i,
  input  wire logic [pcd_pkg::AgentW-1:0] agent_i,
  input  wire logic [pcd_pkg::PosW-1:0]   cell_row_i,
  input  wire logic [pcd_pkg::PosW-1:0]   cell_col_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            kind_o,
  output logic [pcd_pkg::AgentW-1:0]      earlier_agent_o,
  output logic [pcd_pkg::AgentW-1:0]      current_agent_o,
  output logic [pcd_pkg::PosW-1:0]        pos_a_row_o,
  output logic [pcd_pkg::PosW-1:0]        pos_a_col_o,
  output logic [pcd_pkg::PosW-1:0]        pos_b_row_o,
  output logic [pcd_pkg::PosW-1:0]        pos_b_col_o,
  output logic [pcd_pkg::StepW-1:0]       conflict_step_o,
  output logic                            last_o
);
  import pcd_pkg::*;

  localparam int unsigned IdxW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_AGENTS + 1);
  // only the low coordinate bits that fit the port are used
  localparam int unsigned CW   = (COORD_BITS < PosW) ? COORD_BITS : PosW;
  localparam int unsigned OccW = AgentW + 2 * CW;
  localparam int unsigned MovW = AgentW + 4 * CW;
  localparam int unsigned HW   = StepW + 2 * CW;
  localparam logic [CntW-1:0] Full = CntW'(MAX_AGENTS);
  localparam logic [CntW-1:0] Cap  = CntW'(MAX_AGENTS - 1);

  // memories
  logic [OccW-1:0]       occ_mem [MAX_AGENTS];
  logic [MovW-1:0]       mov_mem [MAX_AGENTS];
  logic [HW-1:0]         hist_mem [AgentSlots];
  logic [AgentSlots-1:0] hist_vld_q;

  pcd_state_e state_q, state_d;
  logic [CntW-1:0] occ_cnt_q, mov_cnt_q, addr_q, found_q;
  logic [StepW-1:0] cur_step_q;
  logic started_q;

  logic [StepW-1:0]  s_q;
  logic [AgentW-1:0] a_q;
  logic [CW-1:0]     r_q, c_q;
  logic              dv_q;   // read data holds a table entry
  logic              mv_q;   // agent moved since the previous step

  logic [OccW-1:0] occ_rd_q;
  logic [MovW-1:0] mov_rd_q;
  logic [HW-1:0]   hist_rd_q;

  // newest result of the item, held until the next one or the end shows
  logic              pv_q, pk_q;
  logic [AgentW-1:0] pe_q;

  // output register
  logic              ov_q, ok_q, ol_q;
  logic [AgentW-1:0] oe_q, oc_q;
  logic [CW-1:0]     oar_q, oac_q, obr_q, obc_q;
  logic [StepW-1:0]  ost_q;

  logic accept, ofree, hit, push, adv, scan_end, move_ok, new_step;
  logic [CntW-1:0]   scan_cnt;
  logic [AgentW-1:0] hit_agent;
  logic [CW-1:0]     fr, fc;

  assign fr       = hist_rd_q[2*CW-1:CW];
  assign fc       = hist_rd_q[CW-1:0];
  assign accept   = in_valid_i && in_ready_o;
  assign ofree    = !ov_q || out_ready_i;
  assign new_step = !started_q || (step_i != cur_step_q);

  always_comb begin
    hit       = 1'b0;
    hit_agent = occ_rd_q[OccW-1:2*CW];
    scan_cnt  = occ_cnt_q;
    if (state_q == StOcc) begin
      hit = dv_q && (hit_agent != a_q) &&
            (occ_rd_q[2*CW-1:CW] == r_q) && (occ_rd_q[CW-1:0] == c_q) &&
            (found_q < Cap);
    end else if (state_q == StMove) begin
      scan_cnt  = mov_cnt_q;
      hit_agent = mov_rd_q[MovW-1:4*CW];
      hit = dv_q && (hit_agent != a_q) &&
            (mov_rd_q[4*CW-1:3*CW] == r_q) && (mov_rd_q[3*CW-1:2*CW] == c_q) &&
            (mov_rd_q[2*CW-1:CW] == fr) && (mov_rd_q[CW-1:0] == fc) &&
            (found_q < Cap);
    end
  end

  // the held result leaves on a new hit or at the end of the item
  assign push     = pv_q && (hit || (state_q == StFinish));
  assign adv      = !push || ofree;
  assign scan_end = (addr_q == scan_cnt);
  assign move_ok  = (s_q != '0) && hist_vld_q[a_q] &&
                    (hist_rd_q[HW-1:2*CW] == s_q - StepW'(1)) &&
                    ((fr != r_q) || (fc != c_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (accept) state_d = StOcc;
      StOcc:    if (adv && scan_end) state_d = StHist;
      StHist:   state_d = move_ok ? StMove : StFinish;
      StMove:   if (adv && scan_end) state_d = StFinish;
      StFinish: if (adv) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == StIdle);
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (accept) hist_rd_q <= hist_mem[agent_i];
    if (state_q == StOcc && adv && !scan_end) occ_rd_q <= occ_mem[addr_q[IdxW-1:0]];
    if (state_q == StMove && adv && !scan_end) mov_rd_q <= mov_mem[addr_q[IdxW-1:0]];
    if (state_q == StFinish && adv) begin
      hist_mem[a_q] <= {s_q, r_q, c_q};
      if (occ_cnt_q < Full) occ_mem[occ_cnt_q[IdxW-1:0]] <= {a_q, r_q, c_q};
      if (mv_q && mov_cnt_q < Full) mov_mem[mov_cnt_q[IdxW-1:0]] <= {a_q, fr, fc, r_q, c_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; occ_cnt_q <= '0; mov_cnt_q <= '0; cur_step_q <= '0;
      started_q <= 1'b0; hist_vld_q <= '0; addr_q <= '0; found_q <= '0;
      dv_q <= 1'b0; mv_q <= 1'b0; pv_q <= 1'b0; pk_q <= KindVertex; pe_q <= '0;
      s_q <= '0; a_q <= '0; r_q <= '0; c_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: if (accept) begin
          s_q <= step_i; a_q <= agent_i;
          r_q <= cell_row_i[CW-1:0]; c_q <= cell_col_i[CW-1:0];
          if (new_step) begin
            occ_cnt_q <= '0; mov_cnt_q <= '0;
          end
          cur_step_q <= step_i; started_q <= 1'b1;
          addr_q <= '0; dv_q <= 1'b0; found_q <= '0;
        end
        StOcc: if (adv) begin
          if (hit) begin
            pv_q <= 1'b1; pk_q <= KindVertex; pe_q <= hit_agent;
            found_q <= found_q + CntW'(1);
          end
          if (!scan_end) begin
            addr_q <= addr_q + CntW'(1); dv_q <= 1'b1;
          end else begin
            dv_q <= 1'b0;
          end
        end
        StHist: begin
          addr_q <= '0; dv_q <= 1'b0; found_q <= '0; mv_q <= move_ok;
        end
        StMove: if (adv) begin
          if (hit) begin
            pv_q <= 1'b1; pk_q <= KindEdge; pe_q <= hit_agent;
            found_q <= found_q + CntW'(1);
          end
          if (!scan_end) begin
            addr_q <= addr_q + CntW'(1); dv_q <= 1'b1;
          end else begin
            dv_q <= 1'b0;
          end
        end
        StFinish: if (adv) begin
          pv_q <= 1'b0;
          hist_vld_q[a_q] <= 1'b1;
          if (occ_cnt_q < Full) occ_cnt_q <= occ_cnt_q + CntW'(1);
          if (mv_q && mov_cnt_q < Full) mov_cnt_q <= mov_cnt_q + CntW'(1);
        end
        default: ;
      endcase
    end
  end

  // output register, loaded from the held result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; ok_q <= KindVertex; ol_q <= 1'b0; oe_q <= '0; oc_q <= '0;
      oar_q <= '0; oac_q <= '0; obr_q <= '0; obc_q <= '0; ost_q <= '0;
    end else begin
      if (push && ofree) begin
        ov_q  <= 1'b1;
        ok_q  <= pk_q;
        oe_q  <= pe_q;
        oc_q  <= a_q;
        oar_q <= r_q;
        oac_q <= c_q;
        obr_q <= (pk_q == KindEdge) ? fr : '0;
        obc_q <= (pk_q == KindEdge) ? fc : '0;
        ost_q <= (pk_q == KindEdge) ? s_q - StepW'(1) : s_q;
        ol_q  <= (state_q == StFinish);
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = ok_q;
  assign earlier_agent_o = oe_q;
  assign current_agent_o = oc_q;
  assign pos_a_row_o     = PosW'(oar_q);
  assign pos_a_col_o     = PosW'(oac_q);
  assign pos_b_row_o     = PosW'(obr_q);
  assign pos_b_col_o     = PosW'(obc_q);
  assign conflict_step_o = ost_q;
  assign last_o          = ol_q;

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("ready while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_cnt_q <= Full) && (mov_cnt_q <= Full)) else $error("count overflow");
  a_found_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= Cap) else $error("result cap exceeded");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o &&
      $stable({kind_o, earlier_agent_o, current_agent_o, pos_a_row_o, pos_a_col_o,
               pos_b_row_o, pos_b_col_o, conflict_step_o, last_o})))
    else $error("result changed while waiting");

endmodule

`default_nettype wire
